// File: rtl/tgbc_pkg.sv
package tgbc_pkg;

  localparam logic [31:0] LONG_PRESS_MS = 32'd800;
  localparam logic [31:0] TAP_MAX_MS    = 32'd700;
  localparam logic [31:0] REPEAT_MS     = 32'd200;
  localparam logic [7:0]  EMPTY_SAT     = 8'd255;
  localparam logic [7:0]  HOLD_GAP_FRAMES = 8'd3;
  localparam logic [7:0]  LIFT_FRAMES   = 8'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_TIMEOUT  = 3'd0,
    REG_PROX_THRESH  = 3'd1,
    REG_BRIGHT_STEP  = 3'd2,
    REG_BRIGHT_MIN   = 3'd3,
    REG_BRIGHT_MAX   = 3'd4,
    REG_DIM_LEVEL    = 3'd5,
    REG_TOUCH_EN     = 3'd6,
    REG_PROX_EN      = 3'd7
  } cfg_reg_t;

endpackage

// File: rtl/touch_gesture_backlight_controller.sv
// channel | ports                                   | direction
// --------+-----------------------------------------+-------------------------------
// input   | in_valid, in_stall, in_now_ms .. fields | one frame tick per transaction
// result  | out_valid, out_stall, out_screen ..     | one result per tick
// config  | cfg_we, cfg_idx, cfg_wdata              | register write, no wait
//
// a tick is taken into an input register, evaluated combinationally against the
// gesture state and written to the result register; one tick per cycle when not stalled
// rst_n is synchronous and active low; it clears control state and loads register defaults
// in_stall rises only while the input register is full and the result register is held
// by out_stall, so one transaction can wait in the input register behind a held result
module touch_gesture_backlight_controller #(
  parameter int unsigned PROX_POLL_MS   = 200,
  parameter int unsigned BRIGHT_DEFAULT = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tgbc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tgbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_now_ms,
  input  logic                             in_touched,
  input  logic                             in_up_held,
  input  logic                             in_down_held,
  input  logic [10:0]                      in_prox_level,
  input  logic                             in_data_refreshed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_screen,
  output logic                             out_red_mode,
  output logic                             out_dimmed,
  output logic [7:0]                       out_backlight,
  output logic                             out_redraw
);
  import tgbc_pkg::*;

  // configuration
  logic [21:0] dim_timeout_r;
  logic [10:0] prox_thresh_r;
  logic [7:0]  bright_step_r, bright_min_r, bright_max_r, dim_level_r;
  logic        touch_en_r, prox_en_r;

  // input register
  logic        s1_v_r;
  logic [31:0] s1_now_r;
  logic        s1_touched_r, s1_up_r, s1_down_r, s1_fresh_r;
  logic [10:0] s1_prox_r;

  // gesture state
  logic        in_gesture_r, long_fired_r, ignore_touch_r;
  logic [31:0] gesture_start_r, lift_time_r, last_activity_r, last_prox_poll_r, repeat_due_r;
  logic [7:0]  empty_frames_r, user_level_r;
  logic [1:0]  screen_r, drawn_screen_r;
  logic        red_r, dim_r, drawn_valid_r, drawn_red_r, refresh_pending_r, was_dim_r;

  logic        in_gesture_nxt, long_fired_nxt, ignore_touch_nxt;
  logic [31:0] gesture_start_nxt, lift_time_nxt, last_activity_nxt, last_prox_poll_nxt;
  logic [31:0] repeat_due_nxt;
  logic [7:0]  empty_frames_nxt, user_level_nxt;
  logic [1:0]  screen_nxt, drawn_screen_nxt;
  logic        red_nxt, dim_nxt, drawn_valid_nxt, drawn_red_nxt, refresh_pending_nxt;
  logic        need;

  // result register
  logic        out_v_r;
  logic [1:0]  out_screen_r;
  logic        out_red_r, out_dim_r, out_redraw_r;
  logic [7:0]  out_backlight_r;

  logic adv, fire;

  assign adv      = !out_v_r || !out_stall;
  assign fire     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;

  always_comb begin
    logic        touch_now;
    logic [31:0] held;
    logic signed [9:0] lvl;

    in_gesture_nxt      = in_gesture_r;
    long_fired_nxt      = long_fired_r;
    ignore_touch_nxt    = ignore_touch_r;
    gesture_start_nxt   = gesture_start_r;
    lift_time_nxt       = lift_time_r;
    last_activity_nxt   = last_activity_r;
    last_prox_poll_nxt  = last_prox_poll_r;
    repeat_due_nxt      = repeat_due_r;
    empty_frames_nxt    = empty_frames_r;
    user_level_nxt      = user_level_r;
    screen_nxt          = screen_r;
    red_nxt             = red_r;
    dim_nxt             = dim_r;
    drawn_valid_nxt     = drawn_valid_r;
    drawn_screen_nxt    = drawn_screen_r;
    drawn_red_nxt       = drawn_red_r;
    refresh_pending_nxt = refresh_pending_r || s1_fresh_r;
    held                = 32'd0;
    lvl                 = 10'sd0;

    if (prox_en_r && (s1_now_r - last_prox_poll_r) > 32'(PROX_POLL_MS)) begin
      if (s1_prox_r > prox_thresh_r && dim_nxt) begin
        dim_nxt           = 1'b0;
        last_activity_nxt = s1_now_r;
      end
      last_prox_poll_nxt = s1_now_r;
    end

    if (!dim_nxt && (s1_now_r - last_activity_nxt) > {10'd0, dim_timeout_r})
      dim_nxt = 1'b1;

    // dropout filter: a lift counts only after several empty frames
    touch_now = touch_en_r && s1_touched_r;
    if (touch_now) begin
      empty_frames_nxt = 8'd0;
    end else begin
      if (empty_frames_r == 8'd0)
        lift_time_nxt = s1_now_r;
      if (empty_frames_r < EMPTY_SAT)
        empty_frames_nxt = empty_frames_r + 8'd1;
    end

    if (touch_now && !in_gesture_r) begin
      in_gesture_nxt    = 1'b1;
      gesture_start_nxt = s1_now_r;
      long_fired_nxt    = 1'b0;
      if (dim_nxt) begin
        // wake touch only lights the panel
        dim_nxt           = 1'b0;
        last_activity_nxt = s1_now_r;
        ignore_touch_nxt  = 1'b1;
      end
    end

    if (in_gesture_nxt && empty_frames_nxt < HOLD_GAP_FRAMES && !ignore_touch_nxt &&
        !long_fired_nxt && (s1_now_r - gesture_start_nxt) > LONG_PRESS_MS) begin
      red_nxt           = !red_r;
      last_activity_nxt = s1_now_r;
      long_fired_nxt    = 1'b1;
    end

    if (in_gesture_nxt && empty_frames_nxt >= LIFT_FRAMES) begin
      held = lift_time_nxt - gesture_start_nxt;
      if (!ignore_touch_nxt && !long_fired_nxt && held < TAP_MAX_MS) begin
        screen_nxt        = screen_r + 2'd1;
        last_activity_nxt = s1_now_r;
      end
      in_gesture_nxt   = 1'b0;
      ignore_touch_nxt = 1'b0;
    end

    // up beats down; with min above max, levels under min get min, all others get max
    if (!dim_nxt && (s1_up_r || s1_down_r) && s1_now_r >= repeat_due_r) begin
      if (s1_up_r)
        lvl = $signed({2'b00, user_level_r}) + $signed({2'b00, bright_step_r});
      else
        lvl = $signed({2'b00, user_level_r}) - $signed({2'b00, bright_step_r});
      if (lvl < $signed({2'b00, bright_min_r}))
        lvl = $signed({2'b00, bright_min_r});
      else if (lvl > $signed({2'b00, bright_max_r}))
        lvl = $signed({2'b00, bright_max_r});
      user_level_nxt    = lvl[7:0];
      last_activity_nxt = s1_now_r;
      repeat_due_nxt    = s1_now_r + REPEAT_MS;
    end

    need = (!drawn_valid_r || screen_nxt != drawn_screen_r || red_nxt != drawn_red_r ||
            refresh_pending_nxt || (was_dim_r && !dim_nxt)) && !dim_nxt;
    if (need) begin
      drawn_valid_nxt     = 1'b1;
      drawn_screen_nxt    = screen_nxt;
      drawn_red_nxt       = red_nxt;
      refresh_pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_timeout_r <= 22'd60000;
      prox_thresh_r <= 11'd100;
      bright_step_r <= 8'd16;
      bright_min_r  <= 8'd10;
      bright_max_r  <= 8'd255;
      dim_level_r   <= 8'd5;
      touch_en_r    <= 1'b0;
      prox_en_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_DIM_TIMEOUT: dim_timeout_r <= cfg_wdata;
        REG_PROX_THRESH: prox_thresh_r <= cfg_wdata[10:0];
        REG_BRIGHT_STEP: bright_step_r <= cfg_wdata[7:0];
        REG_BRIGHT_MIN:  bright_min_r  <= cfg_wdata[7:0];
        REG_BRIGHT_MAX:  bright_max_r  <= cfg_wdata[7:0];
        REG_DIM_LEVEL:   dim_level_r   <= cfg_wdata[7:0];
        REG_TOUCH_EN:    touch_en_r    <= cfg_wdata[0];
        REG_PROX_EN:     prox_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv)
        out_v_r <= s1_v_r;
      if (!in_stall)
        s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now_r     <= in_now_ms;
      s1_touched_r <= in_touched;
      s1_up_r      <= in_up_held;
      s1_down_r    <= in_down_held;
      s1_prox_r    <= in_prox_level;
      s1_fresh_r   <= in_data_refreshed;
    end
    if (fire) begin
      out_screen_r    <= screen_nxt;
      out_red_r       <= red_nxt;
      out_dim_r       <= dim_nxt;
      out_backlight_r <= dim_nxt ? dim_level_r : user_level_nxt;
      out_redraw_r    <= need;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_gesture_r      <= 1'b0;
      long_fired_r      <= 1'b0;
      ignore_touch_r    <= 1'b0;
      gesture_start_r   <= 32'd0;
      lift_time_r       <= 32'd0;
      last_activity_r   <= 32'd0;
      last_prox_poll_r  <= 32'd0;
      repeat_due_r      <= 32'd0;
      empty_frames_r    <= 8'd0;
      user_level_r      <= 8'(BRIGHT_DEFAULT);
      screen_r          <= 2'd0;
      red_r             <= 1'b0;
      dim_r             <= 1'b0;
      drawn_valid_r     <= 1'b0;
      drawn_screen_r    <= 2'd0;
      drawn_red_r       <= 1'b0;
      refresh_pending_r <= 1'b0;
      was_dim_r         <= 1'b0;
    end else if (fire) begin
      in_gesture_r      <= in_gesture_nxt;
      long_fired_r      <= long_fired_nxt;
      ignore_touch_r    <= ignore_touch_nxt;
      gesture_start_r   <= gesture_start_nxt;
      lift_time_r       <= lift_time_nxt;
      last_activity_r   <= last_activity_nxt;
      last_prox_poll_r  <= last_prox_poll_nxt;
      repeat_due_r      <= repeat_due_nxt;
      empty_frames_r    <= empty_frames_nxt;
      user_level_r      <= user_level_nxt;
      screen_r          <= screen_nxt;
      red_r             <= red_nxt;
      dim_r             <= dim_nxt;
      drawn_valid_r     <= drawn_valid_nxt;
      drawn_screen_r    <= drawn_screen_nxt;
      drawn_red_r       <= drawn_red_nxt;
      refresh_pending_r <= refresh_pending_nxt;
      was_dim_r         <= dim_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_screen    = out_screen_r;
  assign out_red_mode  = out_red_r;
  assign out_dimmed    = out_dim_r;
  assign out_backlight = out_backlight_r;
  assign out_redraw    = out_redraw_r;

`ifndef SYNTHESIS
  // a dimmed panel is never redrawn
  a_no_redraw_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_dim_r |-> !out_redraw_r)
    else $error("redraw while dimmed");

  // the input register only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && out_v_r && out_stall)
    else $error("stall without held result");

  // gesture state moves only with an evaluated transaction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(screen_r) && $stable(red_r) && $stable(dim_r))
    else $error("state changed without a transaction");

  // a touch clears the empty frame count
  a_touch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && touch_en_r && s1_touched_r |=> empty_frames_r == 8'd0)
    else $error("empty frame count not cleared by touch");
`endif

endmodule
